// ===== sv/nonpreemptive_priority_scheduler_unit_defines.svh =====
// assertion macros for the non-preemptive priority scheduler
// no dependencies; included by modules that carry assertions
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define NPSU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("npsu assertion failed");

// next-cycle implication
`define NPSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("npsu assertion failed");

`endif

// ===== sv/npsu_pkg.sv =====
// shared types and constants for the non-preemptive priority scheduler
// no dependencies
package npsu_pkg;

	localparam int ARR_W       = 16;
	localparam int BURST_W     = 16;
	localparam int PRIO_W      = 8;
	localparam int ID_W        = 7;
	localparam int TIME_W      = 23;
	localparam int MAX_JOBS_DEF = 16;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [ARR_W-1:0]  ARR_MAX  = {ARR_W{1'b1}};

	typedef struct packed {
		logic [ARR_W-1:0]   arr;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
	} job_t;

	typedef struct packed {
		logic clear;
		logic sample;
		logic slot_done;
	} pick_ctrl_t;

	typedef struct packed {
		logic             found;
		job_t             best;
		logic [ARR_W-1:0] min_arr;
	} pick_stat_t;

endpackage

// ===== sv/npsu_job_mem.sv =====
// job store: one write port for loading, one registered read port for the scan
// depends on npsu_pkg
module npsu_job_mem #(
	parameter int MAX_JOBS = npsu_pkg::MAX_JOBS_DEF,
	parameter int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_addr,
	input  npsu_pkg::job_t     wr_data,
	input  logic [IDX_W-1:0]   rd_addr,
	output npsu_pkg::job_t     rd_data
);

	npsu_pkg::job_t mem_q [MAX_JOBS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== sv/npsu_pick_unit.sv =====
// shared compare unit: keeps the best eligible job and the earliest pending arrival
// depends on npsu_pkg
module npsu_pick_unit #(
	parameter int MAX_JOBS = npsu_pkg::MAX_JOBS_DEF,
	parameter int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  npsu_pkg::pick_ctrl_t          ctrl,
	input  logic [IDX_W-1:0]              slot_idx,
	input  npsu_pkg::job_t                slot_job,
	input  logic [npsu_pkg::TIME_W-1:0]   tick,
	output npsu_pkg::pick_stat_t          stat,
	output logic [IDX_W-1:0]              best_idx
);

	logic                     found_q;
	npsu_pkg::job_t           best_q;
	logic [npsu_pkg::ARR_W-1:0] min_arr_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic                     eligible;
	logic                     better;

	assign eligible = !ctrl.slot_done &&
		({{(npsu_pkg::TIME_W - npsu_pkg::ARR_W){1'b0}}, slot_job.arr} <= tick);
	assign better = !found_q || (slot_job.prio > best_q.prio) ||
		((slot_job.prio == best_q.prio) && (slot_job.arr < best_q.arr));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q   <= 1'b0;
			min_arr_q <= npsu_pkg::ARR_MAX;
		end else if (ctrl.clear) begin
			found_q   <= 1'b0;
			min_arr_q <= npsu_pkg::ARR_MAX;
		end else if (ctrl.sample) begin
			if (eligible && better) begin
				found_q <= 1'b1;
			end
			if (!ctrl.slot_done && (slot_job.arr < min_arr_q)) begin
				min_arr_q <= slot_job.arr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.sample && !ctrl.clear && eligible && better) begin
			best_q     <= slot_job;
			best_idx_q <= slot_idx;
		end
	end

	assign stat.found   = found_q;
	assign stat.best    = best_q;
	assign stat.min_arr = min_arr_q;
	assign best_idx     = best_idx_q;

endmodule

// ===== sv/nonpreemptive_priority_scheduler_unit.sv =====
// top level of the non-preemptive priority scheduler: sequencer, done flags and result register
// depends on npsu_pkg, npsu_job_mem, npsu_pick_unit and the defines header
//
// channel  dir  fields
// s_axis   in   tdata: arrival_time, burst_time, job_priority; tlast: last_job
// m_axis   out  tdata: job_id, completion_time, turnaround_time, waiting_time;
//               tlast: last_result
//
// loading stores jobs while the store has room; the item with tlast starts scheduling of N jobs
// each decision scans the store one slot a cycle through the read port,
// then registers the end tick in S_END and the result in S_RES
// an idle gap before pending arrivals costs one more scan of the store
// s_tready is low while scheduling; a result held by m_tready stalls only the next result
// reset is asynchronous, active low, and empties the store and the result register
`include "nonpreemptive_priority_scheduler_unit_defines.svh"

module nonpreemptive_priority_scheduler_unit #(
	parameter int MAX_JOBS = npsu_pkg::MAX_JOBS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // arrival_time[15:0], burst_time[31:16], job_priority[39:32]
	input  logic        s_tlast,   // last_job
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // job_id[6:0], completion_time[29:7],
	                               // turnaround_time[52:30], waiting_time[75:53], zero[79:76]
	output logic        m_tlast    // last_result
);

	localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNT_W = $clog2(MAX_JOBS + 1);
	localparam int TW    = npsu_pkg::TIME_W;

	localparam logic [1:0] S_LOAD = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_END  = 2'd2;
	localparam logic [1:0] S_RES  = 2'd3;

	logic [1:0]          state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    finished_q;
	logic [CNT_W-1:0]    scan_idx_q;
	logic [MAX_JOBS-1:0] done_q;
	logic [TW-1:0]       tick_q;
	logic                rd_v_s1;
	logic [IDX_W-1:0]    rd_idx_s1;

	logic                m_tvalid_q;
	logic [npsu_pkg::ID_W-1:0] id_q;
	logic [TW-1:0]       comp_q;
	logic [TW-1:0]       tat_q;
	logic [TW-1:0]       wait_q;
	logic                last_q;

	logic                s_acc;
	logic                store_room;
	logic                issuing;
	logic                scan_end;
	logic                res_go;
	logic                res_last;
	logic [TW:0]         end_sum;
	logic [TW-1:0]       tat_val;
	logic [TW-1:0]       burst_ext;

	npsu_pkg::job_t       wr_job;
	npsu_pkg::job_t       rd_job;
	npsu_pkg::pick_ctrl_t pctrl;
	npsu_pkg::pick_stat_t pstat;
	logic [IDX_W-1:0]     best_idx;

	assign s_tready   = (state_q == S_LOAD);
	assign s_acc      = s_tvalid && s_tready;
	assign store_room = (count_q < CNT_W'(MAX_JOBS));
	assign issuing    = (state_q == S_SCAN) && (scan_idx_q < count_q);
	assign scan_end   = (state_q == S_SCAN) && !issuing && !rd_v_s1;
	assign res_go     = (state_q == S_RES) && (!m_tvalid_q || m_tready);
	assign res_last   = (finished_q == count_q);

	assign wr_job.arr   = s_tdata[15:0];
	assign wr_job.burst = s_tdata[31:16];
	assign wr_job.prio  = s_tdata[39:32];

	assign burst_ext = {{(TW - npsu_pkg::BURST_W){1'b0}}, pstat.best.burst};
	assign end_sum   = {1'b0, tick_q} + {1'b0, burst_ext};
	assign tat_val   = tick_q - {{(TW - npsu_pkg::ARR_W){1'b0}}, pstat.best.arr};

	assign pctrl.clear     = (s_acc && s_tlast) || (scan_end && !pstat.found) ||
		(res_go && !res_last);
	assign pctrl.sample    = rd_v_s1;
	assign pctrl.slot_done = done_q[rd_idx_s1];

	npsu_job_mem #(.MAX_JOBS(MAX_JOBS), .IDX_W(IDX_W)) u_mem (
		.clk     (clk),
		.wr_en   (s_acc && store_room),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (wr_job),
		.rd_addr (scan_idx_q[IDX_W-1:0]),
		.rd_data (rd_job)
	);

	npsu_pick_unit #(.MAX_JOBS(MAX_JOBS), .IDX_W(IDX_W)) u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (pctrl),
		.slot_idx (rd_idx_s1),
		.slot_job (rd_job),
		.tick     (tick_q),
		.stat     (pstat),
		.best_idx (best_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			count_q    <= '0;
			finished_q <= '0;
			scan_idx_q <= '0;
			done_q     <= '0;
			tick_q     <= '0;
			rd_v_s1    <= 1'b0;
		end else begin
			rd_v_s1 <= issuing;
			case (state_q)
				S_LOAD: begin
					if (s_acc) begin
						if (store_room) begin
							count_q <= count_q + 1'b1;
						end
						if (s_tlast) begin
							state_q    <= S_SCAN;
							tick_q     <= '0;
							finished_q <= '0;
							scan_idx_q <= '0;
						end
					end
				end
				S_SCAN: begin
					if (issuing) begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end else if (scan_end) begin
						if (pstat.found) begin
							state_q <= S_END;
						end else begin
							tick_q     <= {{(TW - npsu_pkg::ARR_W){1'b0}}, pstat.min_arr};
							scan_idx_q <= '0;
						end
					end
				end
				S_END: begin
					tick_q             <= end_sum[TW] ? npsu_pkg::TIME_MAX : end_sum[TW-1:0];
					done_q[best_idx]   <= 1'b1;
					finished_q         <= finished_q + 1'b1;
					state_q            <= S_RES;
				end
				S_RES: begin
					if (res_go) begin
						if (res_last) begin
							state_q    <= S_LOAD;
							count_q    <= '0;
							finished_q <= '0;
							done_q     <= '0;
							tick_q     <= '0;
						end else begin
							state_q    <= S_SCAN;
							scan_idx_q <= '0;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issuing) begin
			rd_idx_s1 <= scan_idx_q[IDX_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_go) begin
			id_q   <= npsu_pkg::ID_W'(best_idx) + 1'b1;
			comp_q <= tick_q;
			tat_q  <= tat_val;
			wait_q <= (tat_val > burst_ext) ? (tat_val - burst_ext) : '0;
			last_q <= res_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, wait_q, tat_q, comp_q, id_q};
	assign m_tlast  = last_q;

	`NPSU_ASSERT_NOW(a_end_has_pick, clk, arst_n, state_q == S_END, pstat.found)
	`NPSU_ASSERT_NOW(a_read_in_range, clk, arst_n, rd_v_s1, {1'b0, rd_idx_s1} < (IDX_W+1)'(count_q))
	`NPSU_ASSERT_NOW(a_finished_bound, clk, arst_n, 1'b1, finished_q <= count_q)
	`NPSU_ASSERT_NEXT(a_set_cleared, clk, arst_n, res_go && res_last, (count_q == '0) && (done_q == '0))

endmodule

// ===== tb/sv/tb_nonpreemptive_priority_scheduler_unit.sv =====
// self-checking testbench for the non-preemptive priority scheduler: job sets on the input
// stream, per-job schedule results on the output stream compared with an internal predictor
// depends on npsu_pkg and nonpreemptive_priority_scheduler_unit
module tb_nonpreemptive_priority_scheduler_unit;

	localparam int RUN_LIMIT    = 600000;
	localparam int RANDOM_ITEMS = 145;
	localparam int TW           = npsu_pkg::TIME_W;
	localparam int IDW          = npsu_pkg::ID_W;
	localparam int NJ           = npsu_pkg::MAX_JOBS_DEF;

	typedef struct packed {
		logic [IDW-1:0] job_id;
		logic [TW-1:0]  done_tick;
		logic [TW-1:0]  turnaround;
		logic [TW-1:0]  waiting;
		logic           last;
	} sched_result_t;

	class sched_scoreboard;
		npsu_pkg::job_t jobs[NJ];
		int unsigned    n_loaded;
		sched_result_t  expected_q[$];
		int             errors;

		function void note_job(npsu_pkg::job_t job, bit last);
			if (n_loaded < NJ) begin
				jobs[n_loaded] = job;
				n_loaded++;
			end
			if (last)
				plan_schedule();
		endfunction

		function void plan_schedule();
			bit            finished_flag[NJ];
			int unsigned   tick;
			int unsigned   end_tick;
			int unsigned   tat;
			int unsigned   next_arr;
			int unsigned   finished;
			int            pick;
			bit            found;
			sched_result_t res;
			tick = 0;
			finished = 0;
			foreach (finished_flag[k])
				finished_flag[k] = 1'b0;
			while (finished < n_loaded) begin
				found = 1'b0;
				pick = 0;
				for (int k = 0; k < n_loaded; k++) begin
					if (finished_flag[k] || jobs[k].arr > tick)
						continue;
					if (!found || jobs[k].prio > jobs[pick].prio ||
					    (jobs[k].prio == jobs[pick].prio && jobs[k].arr < jobs[pick].arr)) begin
						pick = k;
						found = 1'b1;
					end
				end
				if (found) begin
					end_tick = tick + jobs[pick].burst;
					if (end_tick > 32'(npsu_pkg::TIME_MAX))
						end_tick = 32'(npsu_pkg::TIME_MAX);
					tick = end_tick;
					tat = end_tick - jobs[pick].arr;
					finished_flag[pick] = 1'b1;
					finished++;
					res.job_id = IDW'(pick + 1);
					res.done_tick = TW'(end_tick);
					res.turnaround = TW'(tat);
					res.waiting = (tat > jobs[pick].burst) ? TW'(tat - jobs[pick].burst) : '0;
					res.last = (finished == n_loaded);
					expected_q.push_back(res);
				end else begin
					next_arr = 32'hFFFF_FFFF;
					for (int k = 0; k < n_loaded; k++)
						if (!finished_flag[k] && jobs[k].arr < next_arr)
							next_arr = jobs[k].arr;
					tick = next_arr;
				end
			end
			n_loaded = 0;
		endfunction

		function void compare(string field, logic [TW-1:0] want, logic [TW-1:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			end
		endfunction

		function void check_result(logic [79:0] data, logic last);
			sched_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual id %0d", $time,
				         data[6:0]);
				return;
			end
			want = expected_q.pop_front();
			compare("job_id", TW'(want.job_id), TW'(data[6:0]));
			compare("completion_time", want.done_tick, data[29:7]);
			compare("turnaround_time", want.turnaround, data[52:30]);
			compare("waiting_time", want.waiting, data[75:53]);
			compare("last_result", TW'(want.last), TW'(last));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic        m_tlast;

	int              cycle_count = 0;
	int              results_seen = 0;
	sched_scoreboard sb = new();
	wire             calm = (cycle_count >= 3000 && cycle_count < 7000);

	nonpreemptive_priority_scheduler_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("** nonpreemptive_priority_scheduler_unit: FAILED **");
			$finish;
		end
	end

	task automatic send_job(input bit [15:0] arr, input bit [15:0] burst, input bit [7:0] prio,
	                        input bit last);
		npsu_pkg::job_t job;
		job.arr = arr;
		job.burst = burst;
		job.prio = prio;
		while (!calm && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {prio, burst, arr};
		s_tlast <= last;
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		sb.note_job(job, last);
	endtask

	task automatic send_random_set(input int size, input int mode);
		bit [15:0] arr;
		bit [15:0] burst;
		bit [7:0]  prio;
		for (int j = 0; j < size; j++) begin
			case (mode)
				0: begin
					arr = 16'($urandom_range(40));
					burst = 16'($urandom_range(20));
					prio = 8'($urandom_range(3));
				end
				1: begin
					arr = 16'($urandom_range(16'hFFFF));
					burst = 16'($urandom_range(16'hFFFF));
					prio = 8'($urandom_range(8'hFF));
				end
				2: begin
					arr = 16'($urandom_range(40));
					burst = 16'($urandom_range(16'hFFFF));
					prio = 8'($urandom_range(8'hFF));
				end
				default: begin
					arr = 16'($urandom_range(16'hFFFF));
					burst = 16'($urandom_range(30));
					prio = 8'($urandom_range(2));
				end
			endcase
			send_job(arr, burst, prio, j == size - 1);
		end
	endtask

	// receiver with random stalls and one long hold-off
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready) begin
				sb.check_result(m_tdata, m_tlast);
				results_seen++;
			end
			if (!held && results_seen >= 30) begin
				held = 1'b1;
				hold_left = 1500;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 16);
			end
		end
	end

	initial begin
		int n_random;
		int size;
		n_random = 0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single jobs at both extremes, the second forcing an idle jump
		send_job(16'd0, 16'd0, 8'd0, 1'b1);
		send_job(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
		// equal priorities: earlier arrival first, then lower slot
		send_job(16'd5, 16'd3, 8'd7, 1'b0);
		send_job(16'd2, 16'd4, 8'd7, 1'b0);
		send_job(16'd2, 16'd1, 8'd7, 1'b1);
		// idle gap between finished work and later arrivals
		send_job(16'd0, 16'd5, 8'd1, 1'b0);
		send_job(16'd100, 16'd2, 8'd9, 1'b0);
		send_job(16'd50, 16'd1, 8'd3, 1'b1);
		// store full: the job past the last slot is dropped but its last mark still schedules
		for (int i = 0; i <= NJ; i++)
			send_job(16'(i * 3), (i == 0) ? 16'hFFFF : 16'($urandom_range(40)),
			         (i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h00 : 8'($urandom_range(255)),
			         i == NJ);

		while (n_random < RANDOM_ITEMS) begin
			size = ($urandom_range(9) == 0) ? $urandom_range(20, NJ + 1)
			                                : $urandom_range(NJ, 1);
			send_random_set(size, $urandom_range(3));
			n_random += size;
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("** nonpreemptive_priority_scheduler_unit: PASSED **");
		else
			$display("** nonpreemptive_priority_scheduler_unit: FAILED **");
		$finish;
	end

endmodule
